FILE: rtl/fspc_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and palette segment table of the flame and smoke compositor
package fspc_pkg;

    // pipeline depth, one valid bit per stage
    localparam int NUM_STAGES = 10;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FADE          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FLAME_GAIN    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOKE_OPACITY = 2'd2;

    localparam logic [CFG_DATA_W-1:0] FADE_RST          = 16'd32768;
    localparam logic [CFG_DATA_W-1:0] FLAME_GAIN_RST    = 16'd10240;
    localparam logic [CFG_DATA_W-1:0] SMOKE_OPACITY_RST = 16'd15073;

    // q14 constants
    localparam logic [14:0] ONE_Q14      = 15'd16384;
    localparam logic [15:0] K_T_OFF      = 16'd1311;
    localparam logic [14:0] K_T_SCALE    = 15'd23757;
    localparam logic [14:0] K_S_BASE     = 15'd18842;
    localparam logic [13:0] K_S_SCALE    = 14'd9011;
    localparam logic [13:0] K_SMOKE      = 14'd15565;
    localparam logic [14:0] K_PAL_IN     = 15'd19661;
    localparam logic [13:0] K_FLAME_ATT  = 14'd9830;
    localparam logic [13:0] K_SHADE_T    = 14'd11469;
    localparam logic [12:0] K_SHADE_BASE = 13'd1638;
    localparam logic [12:0] K_BLUE_TINT  = 13'd164;
    localparam logic [27:0] FULL_SCALE   = 28'd4177920;

    // palette knots and segment lengths
    localparam int KNOT1     = 4096;
    localparam int KNOT2     = 9011;
    localparam int KNOT3     = 13435;
    localparam int SEG_LEN_0 = KNOT1;
    localparam int SEG_LEN_1 = KNOT2 - KNOT1;
    localparam int SEG_LEN_2 = KNOT3 - KNOT2;
    localparam int SEG_LEN_3 = 16384 - KNOT3;

    // reciprocals floor(2^30 / length) for the segment parameter divide
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_0 = (1 << 30) / SEG_LEN_0;
    localparam int RECIP_1 = (1 << 30) / SEG_LEN_1;
    localparam int RECIP_2 = (1 << 30) / SEG_LEN_2;
    localparam int RECIP_3 = (1 << 30) / SEG_LEN_3;

    localparam logic [1:0] SEG_EMBER  = 2'd0;
    localparam logic [1:0] SEG_RED    = 2'd1;
    localparam logic [1:0] SEG_ORANGE = 2'd2;
    localparam logic [1:0] SEG_WHITE  = 2'd3;

    typedef logic [14:0] q14_t;
    typedef logic [2:0][14:0] rgb_q14_t;
    typedef logic [2:0][7:0] rgb8_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] fade;
        logic [CFG_DATA_W-1:0] flame_gain;
        logic [CFG_DATA_W-1:0] smoke_opacity;
    } cfg_t;

    // flame and smoke terms handed from the weight stages to palette and blend
    typedef struct packed {
        q14_t        p;
        q14_t        factor;
        logic [17:0] gain_flame;
        logic [15:0] alpha_raw;
        logic [20:0] shade_k;
        logic [20:0] shade_blue_k;
        rgb8_t       bg;
    } weight_t;

    typedef struct packed {
        q14_t        start;
        logic [12:0] len;
        logic [18:0] recip;
        q14_t        base_r;
        q14_t        delta_r;
        q14_t        base_g;
        q14_t        delta_g;
        q14_t        base_b;
        q14_t        delta_b;
    } seg_param_t;

    function automatic q14_t sat_one(input logic [16:0] v);
        q14_t r;
        r = (v > 17'(ONE_Q14)) ? ONE_Q14 : v[14:0];
        return r;
    endfunction

    function automatic seg_param_t seg_param(input logic [1:0] seg);
        seg_param_t sp;
        unique case (seg)
            SEG_EMBER: begin
                sp = '{15'd0, 13'(SEG_LEN_0), 19'(RECIP_0),
                       15'd0, 15'd11469, 15'd0, 15'd1638, 15'd0, 15'd0};
            end
            SEG_RED: begin
                sp = '{15'(KNOT1), 13'(SEG_LEN_1), 19'(RECIP_1),
                       15'd11469, 15'd4915, 15'd1638, 15'd8192, 15'd0, 15'd328};
            end
            SEG_ORANGE: begin
                sp = '{15'(KNOT2), 13'(SEG_LEN_2), 19'(RECIP_2),
                       15'd16384, 15'd0, 15'd9830, 15'd5735, 15'd328, 15'd2949};
            end
            SEG_WHITE: begin
                sp = '{15'(KNOT3), 13'(SEG_LEN_3), 19'(RECIP_3),
                       15'd16384, 15'd0, 15'd15565, 15'd819, 15'd3277, 15'd13107};
            end
            default: begin
                sp = '0;
            end
        endcase
        return sp;
    endfunction

endpackage

FILE: rtl/fspc_weight.sv
`timescale 1ns / 1ps
// flame weight, smoke density and shade stages (pipeline stages 0 to 3)
module fspc_weight (
    input  logic                  aclk,
    input  logic [3:0]            en,
    input  logic [15:0]           temperature,
    input  logic [15:0]           smoke_density,
    input  fspc_pkg::rgb8_t       bg,
    input  fspc_pkg::cfg_t        cfg,
    output fspc_pkg::weight_t     w
);

    // stage 0: clamped flame factors, smoke and shade
    logic [15:0] t_off;
    logic [30:0] a_prod;
    logic [29:0] s_prod;
    logic [15:0] s_term;
    logic [15:0] b_diff;
    logic [29:0] smoke_prod;
    logic [29:0] shade_prod;
    fspc_pkg::q14_t shade_sat;
    fspc_pkg::q14_t a_next, b_next, smoke_next;
    logic [12:0] shade_next;

    fspc_pkg::q14_t a_reg, b_reg, smoke_reg;
    logic [12:0] shade_reg;
    fspc_pkg::rgb8_t bg0_reg;

    always_comb begin
        t_off      = (temperature > fspc_pkg::K_T_OFF) ? temperature - fspc_pkg::K_T_OFF : '0;
        a_prod     = 31'(t_off) * 31'(fspc_pkg::K_T_SCALE);
        a_next     = fspc_pkg::sat_one(a_prod[30:14]);
        s_prod     = 30'(smoke_density) * 30'(fspc_pkg::K_S_SCALE);
        s_term     = s_prod[29:14];
        b_diff     = 16'(fspc_pkg::K_S_BASE) - s_term;
        b_next     = (s_term < 16'(fspc_pkg::K_S_BASE)) ? fspc_pkg::sat_one(17'(b_diff)) : '0;
        smoke_prod = 30'(smoke_density) * 30'(fspc_pkg::K_SMOKE);
        smoke_next = fspc_pkg::sat_one(17'(smoke_prod[29:14]));
        shade_prod = 30'(temperature) * 30'(fspc_pkg::K_SHADE_T);
        shade_sat  = fspc_pkg::sat_one(17'(shade_prod[29:14]));
        shade_next = fspc_pkg::K_SHADE_BASE + 13'(shade_sat[14:2]);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            smoke_reg <= smoke_next;
            shade_reg <= shade_next;
            bg0_reg   <= bg;
        end
    end

    // stage 1: unsquared flame, raw smoke alpha, shade scaled to byte units
    logic [29:0] f0_prod;
    logic [30:0] alpha_prod;
    logic [12:0] shade_blue;
    fspc_pkg::q14_t f0_reg;
    logic [15:0] alpha_raw_reg;
    logic [20:0] shade_k_reg, shade_blue_k_reg;
    fspc_pkg::rgb8_t bg1_reg;

    always_comb begin
        f0_prod    = 30'(a_reg) * 30'(b_reg);
        alpha_prod = 31'(cfg.smoke_opacity) * 31'(smoke_reg);
        shade_blue = shade_reg + fspc_pkg::K_BLUE_TINT;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            f0_reg           <= f0_prod[28:14];
            alpha_raw_reg    <= alpha_prod[29:14];
            shade_k_reg      <= 21'(shade_reg) * 21'd255;
            shade_blue_k_reg <= 21'(shade_blue) * 21'd255;
            bg1_reg          <= bg0_reg;
        end
    end

    // stage 2: squared flame weight
    logic [29:0] flame_prod;
    fspc_pkg::q14_t flame_reg;
    logic [15:0] alpha_raw2_reg;
    logic [20:0] shade_k2_reg, shade_blue_k2_reg;
    fspc_pkg::rgb8_t bg2_reg;

    assign flame_prod = 30'(f0_reg) * 30'(f0_reg);

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            flame_reg         <= flame_prod[28:14];
            alpha_raw2_reg    <= alpha_raw_reg;
            shade_k2_reg      <= shade_k_reg;
            shade_blue_k2_reg <= shade_blue_k_reg;
            bg2_reg           <= bg1_reg;
        end
    end

    // stage 3: palette position, smoke attenuation, flame gain
    logic [29:0] p_prod;
    logic [28:0] att_prod;
    logic [30:0] gain_prod;
    fspc_pkg::weight_t w_next;
    fspc_pkg::weight_t w_reg;

    always_comb begin
        p_prod    = 30'(flame_reg) * 30'(fspc_pkg::K_PAL_IN);
        att_prod  = 29'(fspc_pkg::K_FLAME_ATT) * 29'(flame_reg);
        gain_prod = 31'(cfg.flame_gain) * 31'(flame_reg);
        w_next.p            = fspc_pkg::sat_one(17'(p_prod[29:14]));
        w_next.factor       = fspc_pkg::ONE_Q14 - att_prod[28:14];
        w_next.gain_flame   = gain_prod[30:13];
        w_next.alpha_raw    = alpha_raw2_reg;
        w_next.shade_k      = shade_k2_reg;
        w_next.shade_blue_k = shade_blue_k2_reg;
        w_next.bg           = bg2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            w_reg <= w_next;
        end
    end

    assign w = w_reg;

endmodule

FILE: rtl/fspc_palette.sv
`timescale 1ns / 1ps
// piecewise-linear fire palette lookup (pipeline stages 4 to 6)
module fspc_palette (
    input  logic                 aclk,
    input  logic [2:0]           en,
    input  fspc_pkg::q14_t       p,
    output fspc_pkg::rgb_q14_t   col
);

    // stage 0: segment select and reciprocal estimate of the segment parameter
    logic [1:0] seg_next;
    fspc_pkg::seg_param_t sp0;
    fspc_pkg::q14_t x_full;
    logic [31:0] q_prod;
    logic [1:0] seg0_reg;
    logic [12:0] x_reg;
    fspc_pkg::q14_t q_est_reg;

    always_comb begin
        if (p < 15'(fspc_pkg::KNOT1)) begin
            seg_next = fspc_pkg::SEG_EMBER;
        end else if (p < 15'(fspc_pkg::KNOT2)) begin
            seg_next = fspc_pkg::SEG_RED;
        end else if (p < 15'(fspc_pkg::KNOT3)) begin
            seg_next = fspc_pkg::SEG_ORANGE;
        end else begin
            seg_next = fspc_pkg::SEG_WHITE;
        end
        sp0    = fspc_pkg::seg_param(seg_next);
        x_full = p - sp0.start;
        q_prod = 32'(x_full[12:0]) * 32'(sp0.recip);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            seg0_reg  <= seg_next;
            x_reg     <= x_full[12:0];
            q_est_reg <= q_prod[fspc_pkg::RECIP_SHIFT +: 15];
        end
    end

    // stage 1: estimate is at most one low, fix it from the remainder
    fspc_pkg::seg_param_t sp1;
    logic [27:0] num;
    logic [27:0] qd;
    logic [27:0] rem;
    fspc_pkg::q14_t k_next;
    logic [1:0] seg1_reg;
    fspc_pkg::q14_t k_reg;

    always_comb begin
        sp1    = fspc_pkg::seg_param(seg0_reg);
        num    = {1'b0, x_reg, 14'b0};
        qd     = 28'(q_est_reg) * 28'(sp1.len);
        rem    = num - qd;
        k_next = (rem >= 28'(sp1.len)) ? q_est_reg + 15'd1 : q_est_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            seg1_reg <= seg0_reg;
            k_reg    <= k_next;
        end
    end

    // stage 2: interpolate each channel between the knot colors
    fspc_pkg::seg_param_t sp2;
    logic [2:0][14:0] base;
    logic [2:0][14:0] delta;
    logic [29:0] lerp_prod;
    fspc_pkg::rgb_q14_t col_next;
    fspc_pkg::rgb_q14_t col_reg;

    always_comb begin
        sp2      = fspc_pkg::seg_param(seg1_reg);
        base     = {sp2.base_b, sp2.base_g, sp2.base_r};
        delta    = {sp2.delta_b, sp2.delta_g, sp2.delta_r};
        col_next = '0;
        lerp_prod = '0;
        for (int c = 0; c < 3; c++) begin
            lerp_prod   = 30'(delta[c]) * 30'(k_reg);
            col_next[c] = base[c] + lerp_prod[28:14];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            col_reg <= col_next;
        end
    end

    assign col = col_reg;

endmodule

FILE: rtl/fspc_blend.sv
`timescale 1ns / 1ps
// smoke alpha blend, flame addition and output saturation (pipeline stages 4 to 9)
module fspc_blend (
    input  logic                 aclk,
    input  logic [5:0]           en,
    input  fspc_pkg::cfg_t       cfg,
    input  fspc_pkg::weight_t    w,
    input  fspc_pkg::rgb_q14_t   col,
    output fspc_pkg::rgb8_t      pix
);

    // stage 0: faded flame addition and attenuated smoke alpha
    logic [33:0] add_prod;
    logic [30:0] alpha2_prod;
    logic [17:0] add0_reg;
    logic [15:0] alpha2_reg;
    logic [20:0] shade_k0_reg, shade_blue_k0_reg;
    fspc_pkg::rgb8_t bg0_reg;

    always_comb begin
        add_prod    = 34'(w.gain_flame) * 34'(cfg.fade);
        alpha2_prod = 31'(w.alpha_raw) * 31'(w.factor);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            add0_reg          <= add_prod[32:15];
            alpha2_reg        <= alpha2_prod[29:14];
            shade_k0_reg      <= w.shade_k;
            shade_blue_k0_reg <= w.shade_blue_k;
            bg0_reg           <= w.bg;
        end
    end

    // stage 1: final alpha after fade, clamped to one
    logic [31:0] alpha3_prod;
    fspc_pkg::q14_t alpha_reg;
    logic [17:0] add1_reg;
    logic [20:0] shade_k1_reg, shade_blue_k1_reg;
    fspc_pkg::rgb8_t bg1_reg;

    assign alpha3_prod = 32'(alpha2_reg) * 32'(cfg.fade);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            alpha_reg         <= fspc_pkg::sat_one(alpha3_prod[31:15]);
            add1_reg          <= add0_reg;
            shade_k1_reg      <= shade_k0_reg;
            shade_blue_k1_reg <= shade_blue_k0_reg;
            bg1_reg           <= bg0_reg;
        end
    end

    // stage 2: background and smoke shade terms
    fspc_pkg::q14_t inv_alpha;
    logic [35:0] sm_prod, smb_prod;
    logic [2:0][21:0] bgt_next;
    logic [2:0][21:0] bgt_reg;
    logic [20:0] sm_reg, smb_reg;
    logic [17:0] add2_reg;

    always_comb begin
        inv_alpha = fspc_pkg::ONE_Q14 - alpha_reg;
        sm_prod   = 36'(shade_k1_reg) * 36'(alpha_reg);
        smb_prod  = 36'(shade_blue_k1_reg) * 36'(alpha_reg);
        for (int c = 0; c < 3; c++) begin
            bgt_next[c] = 22'(bg1_reg[c]) * 22'(inv_alpha);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            bgt_reg  <= bgt_next;
            sm_reg   <= sm_prod[34:14];
            smb_reg  <= smb_prod[34:14];
            add2_reg <= add1_reg;
        end
    end

    // stage 3: flame product and blended background
    logic [2:0][32:0] ft_next;
    logic [2:0][22:0] bl_next;
    logic [2:0][32:0] ft_reg;
    logic [2:0][22:0] bl_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ft_next[c] = 33'(col[c]) * 33'(add2_reg);
        end
        bl_next[0] = 23'(bgt_reg[0]) + 23'(sm_reg);
        bl_next[1] = 23'(bgt_reg[1]) + 23'(sm_reg);
        bl_next[2] = 23'(bgt_reg[2]) + 23'(smb_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            ft_reg <= ft_next;
            bl_reg <= bl_next;
        end
    end

    // stage 4: flame term in byte units, times 255 as shift and subtract
    logic [2:0][40:0] ft255;
    logic [2:0][26:0] ftx_reg;
    logic [2:0][22:0] bl4_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ft255[c] = {ft_reg[c], 8'b0} - 41'(ft_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int c = 0; c < 3; c++) begin
                ftx_reg[c] <= ft255[c][40:14];
            end
            bl4_reg <= bl_reg;
        end
    end

    // stage 5: sum, saturate at full scale, take the byte
    logic [2:0][27:0] v_sum;
    logic [2:0][27:0] v_sat;
    fspc_pkg::rgb8_t pix_next;
    fspc_pkg::rgb8_t pix_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            v_sum[c]    = 28'(bl4_reg[c]) + 28'(ftx_reg[c]);
            v_sat[c]    = (v_sum[c] > fspc_pkg::FULL_SCALE) ? fspc_pkg::FULL_SCALE : v_sum[c];
            pix_next[c] = v_sat[c][21:14];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

FILE: rtl/flame_smoke_pixel_compositor_core.sv
`timescale 1ns / 1ps
// top level of the flame and smoke pixel compositor
//
//   channel   direction  transfer contents
//   s_axis    in         temperature, smoke density, background rgb bytes
//   m_axis    out        composited rgb bytes
//   cfg       in         fade, flame gain, smoke opacity register writes
//
// one pixel per cycle sustained while m_tready stays high; ten register stages lie
// between the input transfer and m_tvalid
// the ten register stages are set by the multiplier chain flame -> squared flame
// -> palette divide -> flame product -> saturation, at most one multiply deep per stage
// each stage holds its item until the next stage is free, so a stall at m_axis
// only fills bubbles and s_tready stays high while any stage is empty
// aresetn (synchronous, active low) clears the stage valid bits and restores the
// register reset values; stage payload flops are not reset
module flame_smoke_pixel_compositor_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] temperature, [31:16] smoke_density, [39:32] background_red,
    // [47:40] background_green, [55:48] background_blue
    input  logic [55:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [23:0] m_tdata,

    input  logic                                cfg_we,
    input  logic [fspc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fspc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int NS = fspc_pkg::NUM_STAGES;

    // configuration registers
    fspc_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                fspc_pkg::REG_FADE:          cfg_next.fade          = cfg_wdata;
                fspc_pkg::REG_FLAME_GAIN:    cfg_next.flame_gain    = cfg_wdata;
                fspc_pkg::REG_SMOKE_OPACITY: cfg_next.smoke_opacity = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fade          <= fspc_pkg::FADE_RST;
            cfg_reg.flame_gain    <= fspc_pkg::FLAME_GAIN_RST;
            cfg_reg.smoke_opacity <= fspc_pkg::SMOKE_OPACITY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // stage valid bits; a stage loads when it or any later stage is empty, or the output takes its transfer
    logic [NS-1:0] v_reg, v_next;
    logic [NS-1:0] adv;

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_adv
            // any bubble at or after this stage, or the output taking its transfer
            assign adv[gi] = m_tready | ~(&v_reg[NS-1:gi]);
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            if (adv[i]) begin
                v_next[i] = (i == 0) ? s_tvalid : v_reg[(i == 0) ? 0 : i - 1];
            end else begin
                v_next[i] = v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = v_reg[NS-1];

    // input unpack
    fspc_pkg::rgb8_t bg_in;
    assign bg_in = {s_tdata[55:48], s_tdata[47:40], s_tdata[39:32]};

    // flame weight, smoke and shade: stages 0 to 3
    fspc_pkg::weight_t w;

    fspc_weight u_weight (
        .aclk          (aclk),
        .en            (adv[3:0]),
        .temperature   (s_tdata[15:0]),
        .smoke_density (s_tdata[31:16]),
        .bg            (bg_in),
        .cfg           (cfg_reg),
        .w             (w)
    );

    // fire palette: stages 4 to 6
    fspc_pkg::rgb_q14_t col;

    fspc_palette u_palette (
        .aclk (aclk),
        .en   (adv[6:4]),
        .p    (w.p),
        .col  (col)
    );

    // smoke blend, flame add, saturation: stages 4 to 9
    fspc_pkg::rgb8_t pix;

    fspc_blend u_blend (
        .aclk (aclk),
        .en   (adv[9:4]),
        .cfg  (cfg_reg),
        .w    (w),
        .col  (col),
        .pix  (pix)
    );

    assign m_tdata = {pix[2], pix[1], pix[0]};

`ifndef SYNTHESIS
    // items in flight change only by input and output transfers
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            ($countones(v_reg) == $past($countones(v_reg))
                + int'($past(s_tvalid && s_tready))
                - int'($past(m_tvalid && m_tready))))
        else $error("pipeline occupancy does not track transfers");

    // an empty stage anywhere lets a new pixel in
    a_ready_on_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        !(&v_reg) |-> s_tready)
        else $error("input stalled while the pipeline has a free stage");

    // nothing is presented in the first cycle after reset is released
    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the flame and smoke pixel compositor core
module tb_top;

    // ------------------------------------------------------------------
    // fixed-point constants of the compositing math, all in q14
    // ------------------------------------------------------------------
    localparam logic [63:0] Q14_ONE       = 64'd16384;
    localparam logic [63:0] TEMP_OFFSET   = 64'd1311;   // 0.08
    localparam logic [63:0] TEMP_SCALE    = 64'd23757;  // 1.45
    localparam logic [63:0] SOOT_BASE     = 64'd18842;  // 1.15
    localparam logic [63:0] SOOT_SCALE    = 64'd9011;   // 0.55
    localparam logic [63:0] SMOKE_SCALE   = 64'd15565;  // 0.95
    localparam logic [63:0] PALETTE_SCALE = 64'd19661;  // 1.2
    localparam logic [63:0] FLAME_SHADOW  = 64'd9830;   // 0.6
    localparam logic [63:0] SHADE_TEMP    = 64'd11469;  // 0.7
    localparam logic [63:0] SHADE_FLOOR   = 64'd1638;   // 0.10
    localparam logic [63:0] BLUE_TINT     = 64'd164;    // 0.01
    localparam logic [63:0] PAL_KNOT1     = 64'd4096;
    localparam logic [63:0] PAL_KNOT2     = 64'd9011;
    localparam logic [63:0] PAL_KNOT3     = 64'd13435;
    localparam logic [63:0] CHANNEL_FULL  = 64'd255 * 64'd16384;

    localparam int CYCLE_LIMIT = 800000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0] temperature;
        logic [15:0] smoke_density;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // ------------------------------------------------------------------
    // clock, reset and dut ports
    // ------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    logic                                cfg_we = 1'b0;
    logic [fspc_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [fspc_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

    flame_smoke_pixel_compositor_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // ------------------------------------------------------------------
    // shadow copy of the registers and the queue of predicted pixels
    // ------------------------------------------------------------------
    logic [63:0] fade_q15;
    logic [63:0] gain_q13;
    logic [63:0] opacity_q14;

    rgb_t expected_colors[$];

    int errors = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int settings_used = 1;
    int cycle_count = 0;

    // idling controls shared by the sender, the sink and the tests
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_left = 0;

    function automatic logic [63:0] clamp_q14(input logic [63:0] v);
        return (v > Q14_ONE) ? Q14_ONE : v;
    endfunction

    // predicted composited pixel for the current register settings
    function automatic rgb_t composite(input pixel_t px);
        logic [63:0] t, s, heat, soot, s_term, core, flame, smoke, p, k;
        logic [63:0] add, alpha, shade, v;
        logic [2:0][63:0] fire;
        logic [2:0][63:0] tone;
        logic [2:0][63:0] bg;
        logic [2:0][7:0] res;
        rgb_t c;
        t = 64'(px.temperature);
        s = 64'(px.smoke_density);
        bg[0] = 64'(px.red);
        bg[1] = 64'(px.green);
        bg[2] = 64'(px.blue);

        // flame weight: heat times soot factor, then squared
        heat = (t > TEMP_OFFSET) ? clamp_q14(((t - TEMP_OFFSET) * TEMP_SCALE) >> 14) : 64'd0;
        s_term = (s * SOOT_SCALE) >> 14;
        soot = (s_term < SOOT_BASE) ? clamp_q14(SOOT_BASE - s_term) : 64'd0;
        core = (heat * soot) >> 14;
        flame = (core * core) >> 14;
        smoke = clamp_q14((s * SMOKE_SCALE) >> 14);

        // fire palette, four linear segments with a floored segment parameter
        p = clamp_q14((flame * PALETTE_SCALE) >> 14);
        if (p < PAL_KNOT1) begin
            k = (p << 14) / PAL_KNOT1;
            fire[0] = (64'd11469 * k) >> 14;
            fire[1] = (64'd1638 * k) >> 14;
            fire[2] = 64'd0;
        end else if (p < PAL_KNOT2) begin
            k = ((p - PAL_KNOT1) << 14) / (PAL_KNOT2 - PAL_KNOT1);
            fire[0] = 64'd11469 + ((64'd4915 * k) >> 14);
            fire[1] = 64'd1638 + ((64'd8192 * k) >> 14);
            fire[2] = (64'd328 * k) >> 14;
        end else if (p < PAL_KNOT3) begin
            k = ((p - PAL_KNOT2) << 14) / (PAL_KNOT3 - PAL_KNOT2);
            fire[0] = Q14_ONE;
            fire[1] = 64'd9830 + ((64'd5735 * k) >> 14);
            fire[2] = 64'd328 + ((64'd2949 * k) >> 14);
        end else begin
            k = ((p - PAL_KNOT3) << 14) / (Q14_ONE - PAL_KNOT3);
            fire[0] = Q14_ONE;
            fire[1] = 64'd15565 + ((64'd819 * k) >> 14);
            fire[2] = 64'd3277 + ((64'd13107 * k) >> 14);
        end

        add = (((gain_q13 * flame) >> 13) * fade_q15) >> 15;

        // smoke opacity, thinned where the flame is bright
        alpha = (opacity_q14 * smoke) >> 14;
        alpha = (alpha * (Q14_ONE - ((FLAME_SHADOW * flame) >> 14))) >> 14;
        alpha = clamp_q14((alpha * fade_q15) >> 15);

        shade = SHADE_FLOOR + (clamp_q14((t * SHADE_TEMP) >> 14) >> 2);
        tone[0] = shade;
        tone[1] = shade;
        tone[2] = shade + BLUE_TINT;

        for (int i = 0; i < 3; i++) begin
            v = (bg[i] * Q14_ONE * (Q14_ONE - alpha) + tone[i] * 64'd255 * alpha) >> 14;
            v = v + ((fire[i] * add * 64'd255) >> 14);
            if (v > CHANNEL_FULL) begin
                v = CHANNEL_FULL;
            end
            res[i] = v[21:14];
        end
        c.red = res[0];
        c.green = res[1];
        c.blue = res[2];
        return c;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------
    // mostly no gap, some short, a few long
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // q2.14 input value: mostly in range, some over-range, some near the corners
    function automatic logic [15:0] rand_q14_in();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 16'($urandom_range(0, 32768));
        end else if (r < 85) begin
            return 16'($urandom);
        end else if (r < 93) begin
            return 16'($urandom_range(0, 2000));
        end
        return 16'($urandom_range(12000, 16384));
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        px.temperature = rand_q14_in();
        px.smoke_density = rand_q14_in();
        px.red = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue = 8'($urandom_range(0, 255));
        return px;
    endfunction

    // register value: mostly within its range, sometimes any 16 bit value
    function automatic logic [15:0] rand_reg(input int upper);
        if ($urandom_range(0, 9) < 8) begin
            return 16'($urandom_range(0, upper));
        end
        return 16'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    // offers one pixel and predicts its color once the transfer happens
    task automatic send_pixel(input pixel_t px);
        int gap;
        gap = pick_gap(tx_idle_on);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {px.blue, px.green, px.red, px.smoke_density, px.temperature};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        expected_colors.insert(expected_colors.size(), composite(px));
        pixels_sent++;
    endtask

    // sender goes quiet until every predicted pixel has come back
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [fspc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == fspc_pkg::REG_FADE) begin
            fade_q15 = 64'(value);
        end else if (idx == fspc_pkg::REG_FLAME_GAIN) begin
            gain_q13 = 64'(value);
        end else if (idx == fspc_pkg::REG_SMOKE_OPACITY) begin
            opacity_q14 = 64'(value);
        end
    endtask

    // registers change only with the pipeline empty
    task automatic apply_settings(input logic [15:0] fade, input logic [15:0] gain,
                                  input logic [15:0] opacity);
        wait_for_drain();
        write_reg(fspc_pkg::REG_FADE, fade);
        write_reg(fspc_pkg::REG_FLAME_GAIN, gain);
        write_reg(fspc_pkg::REG_SMOKE_OPACITY, opacity);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // result sink: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int idle_left;
        idle_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_tready <= 1'b0;
            end else begin
                idle_left = pick_gap(rx_idle_on);
                if (idle_left > 0) begin
                    idle_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result check against the oldest prediction
    // ------------------------------------------------------------------
    rgb_t want;
    rgb_t got;

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = rgb_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]});
            if (expected_colors.size() == 0) begin
                note_error($sformatf("unexpected output transfer rgb=%0d,%0d,%0d",
                                     got.red, got.green, got.blue));
            end else begin
                want = expected_colors.pop_front();
                pixels_checked++;
                if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue) begin
                    note_error($sformatf("pixel %0d mismatch: expected rgb=%0d,%0d,%0d got %0d,%0d,%0d",
                                         pixels_checked - 1, want.red, want.green, want.blue,
                                         got.red, got.green, got.blue));
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d pixels still pending",
                 cycle_count, expected_colors.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // corners of every field, each palette segment, the flame offset and soot cut-off,
    // all at the reset register values
    task automatic test_directed_corners();
        send_pixel(pixel_t'({16'd0,     16'd0,     8'd0,   8'd0,   8'd0}));
        send_pixel(pixel_t'({16'd0,     16'd0,     8'd255, 8'd255, 8'd255}));
        send_pixel(pixel_t'({16'd1310,  16'd0,     8'd10,  8'd20,  8'd30}));
        send_pixel(pixel_t'({16'd1311,  16'd0,     8'd10,  8'd20,  8'd30}));
        send_pixel(pixel_t'({16'd1312,  16'd0,     8'd10,  8'd20,  8'd30}));
        send_pixel(pixel_t'({16'd3000,  16'd0,     8'd0,   8'd0,   8'd0}));
        send_pixel(pixel_t'({16'd5000,  16'd0,     8'd0,   8'd0,   8'd0}));
        send_pixel(pixel_t'({16'd7000,  16'd0,     8'd0,   8'd0,   8'd0}));
        send_pixel(pixel_t'({16'd9500,  16'd0,     8'd0,   8'd0,   8'd0}));
        send_pixel(pixel_t'({16'd11000, 16'd0,     8'd0,   8'd0,   8'd0}));
        send_pixel(pixel_t'({16'd12608, 16'd0,     8'd0,   8'd0,   8'd0}));
        send_pixel(pixel_t'({16'd16384, 16'd0,     8'd200, 8'd100, 8'd50}));
        send_pixel(pixel_t'({16'd32768, 16'd0,     8'd255, 8'd255, 8'd255}));
        send_pixel(pixel_t'({16'd65535, 16'd0,     8'd255, 8'd0,   8'd255}));
        send_pixel(pixel_t'({16'd0,     16'd16384, 8'd255, 8'd255, 8'd255}));
        send_pixel(pixel_t'({16'd0,     16'd32768, 8'd0,   8'd0,   8'd0}));
        send_pixel(pixel_t'({16'd0,     16'd65535, 8'd128, 8'd128, 8'd128}));
        send_pixel(pixel_t'({16'd16384, 16'd16384, 8'd90,  8'd90,  8'd90}));
        send_pixel(pixel_t'({16'd32768, 16'd32768, 8'd0,   8'd255, 8'd0}));
        send_pixel(pixel_t'({16'd65535, 16'd65535, 8'd0,   8'd255, 8'd0}));
        send_pixel(pixel_t'({16'd8000,  16'd8000,  8'd128, 8'd64,  8'd32}));
        // smoke just before and just past the point where the soot factor reaches zero
        send_pixel(pixel_t'({16'd12608, 16'd34257, 8'd60,  8'd60,  8'd60}));
        send_pixel(pixel_t'({16'd12608, 16'd34300, 8'd60,  8'd60,  8'd60}));
        wait_for_drain();
    endtask

    // fixed settings including zero, full scale and all ones in every register
    task automatic test_register_sweep();
        logic [15:0] fades [9];
        logic [15:0] gains [9];
        logic [15:0] opacities [9];
        fades = '{16'd32768, 16'd0, 16'hFFFF, 16'd32768, 16'd0, 16'd32768, 16'd16384,
                  16'd32768, 16'd24000};
        gains = '{16'd10240, 16'd0, 16'hFFFF, 16'd40960, 16'd40960, 16'd0, 16'd8192,
                  16'd40960, 16'd20000};
        opacities = '{16'd15073, 16'd0, 16'hFFFF, 16'd49152, 16'd49152, 16'd0, 16'd16384,
                      16'd0, 16'd30000};
        for (int i = 0; i < 9; i++) begin
            apply_settings(fades[i], gains[i], opacities[i]);
            repeat (36) send_pixel(rand_pixel());
        end
        wait_for_drain();
    endtask

    // main random stream with idling on both sides and fresh settings per phase
    task automatic test_random_stream();
        for (int phase = 0; phase < 6; phase++) begin
            apply_settings(rand_reg(32768), rand_reg(40960), rand_reg(49152));
            repeat (230) send_pixel(rand_pixel());
        end
        wait_for_drain();
    endtask

    // sink holds off long enough for the pipeline to fill and stall the input,
    // then the sender pauses until everything has come back
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_hold_left = 200;
        repeat (60) send_pixel(rand_pixel());
        wait_for_drain();
        rx_hold_left = 120;
        repeat (30) send_pixel(rand_pixel());
        wait_for_drain();
        tx_idle_on = 1'b1;
    endtask

    // back-to-back transfers with no idling anywhere
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (150) send_pixel(rand_pixel());
        wait_for_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        fade_q15 = 64'(fspc_pkg::FADE_RST);
        gain_q13 = 64'(fspc_pkg::FLAME_GAIN_RST);
        opacity_q14 = 64'(fspc_pkg::SMOKE_OPACITY_RST);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_corners();
        test_full_rate();
        test_backpressure();
        test_register_sweep();
        test_random_stream();

        wait_for_drain();
        // catch any stray output after the last expected pixel
        repeat (2 * fspc_pkg::NUM_STAGES) @(posedge aclk);

        $display("sent %0d pixels, checked %0d composited results", pixels_sent,
                 pixels_checked);
        $display("covered %0d register settings incl. zero and all-ones, stalls and full rate",
                 settings_used);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/fspc_pkg.sv
rtl/fspc_weight.sv
rtl/fspc_palette.sv
rtl/fspc_blend.sv
rtl/flame_smoke_pixel_compositor_core.sv
bench/tb_top.sv
